@@ rtl/core/lcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LED chaser sequencer package
// Shared widths, codes, reset values, types and the LED pattern function.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned MS_W       = 12;
    localparam int unsigned LED_W      = 4;
    localparam int unsigned PAT_W      = 2;
    localparam int unsigned SPEED_W    = 3;
    localparam int unsigned POS_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned LEVEL_NUM  = 5;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPEED = 2'd2;

    // Pattern selections
    localparam logic [PAT_W-1:0] PAT_LEFT  = 2'd0;
    localparam logic [PAT_W-1:0] PAT_RIGHT = 2'd1;
    localparam logic [PAT_W-1:0] PAT_ALT   = 2'd2;

    // Speed levels
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 3'd0;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 3'd4;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 3'd2;

    // Duration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL4 = 3'd4;

    localparam logic [MS_W-1:0] LEVEL0_RESET = 12'd1000;
    localparam logic [MS_W-1:0] LEVEL1_RESET = 12'd500;
    localparam logic [MS_W-1:0] LEVEL2_RESET = 12'd250;
    localparam logic [MS_W-1:0] LEVEL3_RESET = 12'd125;
    localparam logic [MS_W-1:0] LEVEL4_RESET = 12'd62;

    localparam logic [LED_W-1:0] LED_FIRST = 4'b0001;
    localparam logic [LED_W-1:0] LED_LAST  = 4'b1000;
    localparam logic [LED_W-1:0] LED_EVEN  = 4'b0101;
    localparam logic [LED_W-1:0] LED_ODD   = 4'b1010;

    typedef logic [MS_W-1:0] step_ms_t;
    typedef step_ms_t [LEVEL_NUM-1:0] level_table_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic              pin_level;
    } lcs_event_t;

    typedef struct packed {
        logic [LED_W-1:0]   leds;
        logic [PAT_W-1:0]   pattern_index;
        logic [SPEED_W-1:0] speed_index;
    } lcs_result_t;

    function automatic logic [LED_W-1:0] leds_for(input logic [PAT_W-1:0] pat,
                                                 input logic [POS_W-1:0] pos);
        logic [LED_W-1:0] led;
        led = LED_FIRST;
        case (pat)
            PAT_LEFT:  led = LED_FIRST << pos;
            PAT_RIGHT: led = LED_LAST >> pos;
            default:   led = pos[0] ? LED_ODD : LED_EVEN;
        endcase
        return led;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/led_chaser_sequencer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LED chaser sequencer core
// Four-LED chaser driven by millisecond ticks and button events.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one event per transfer; s_kind selects a millisecond tick,
//   a pattern-button press or a speed-button level sample (s_pin_level).
//   m_ channel: one result per event, the LED drive, pattern and speed
//   selection as they stand after that event.
//   cfg_ channel: writes the five step-duration registers (ms per step);
//   always ready, and writes to an index above four are dropped. A new
//   duration is used from the start of the following step.
// Order: an event passes the input register, then the result register.
// Throughput: one event per cycle while m_ready is high; the state update
//   is a single pass of short logic between the input and result registers.
// Reset: aresetn clears both register stages and restores the register
//   defaults, speed level two, pattern zero and LED pattern 0001.
// Stall: when m_ready is low the result register holds; the input register
//   then fills and s_ready falls until the result is taken.
// ----------------------------------------------------------------------------
module led_chaser_sequencer_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Event channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [lcs_pkg::KIND_W-1:0]        s_kind,
    input  wire logic                              s_pin_level,
    // Result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [lcs_pkg::LED_W-1:0]              m_leds,
    output logic [lcs_pkg::PAT_W-1:0]              m_pattern_index,
    output logic [lcs_pkg::SPEED_W-1:0]            m_speed_index,
    // Configuration channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lcs_pkg::MS_W-1:0]          cfg_data
);

    logic                          in_valid_reg;
    logic [lcs_pkg::KIND_W-1:0]    in_kind_reg;
    logic                          in_pin_reg;
    logic                          out_valid_reg;
    lcs_pkg::lcs_result_t          out_reg;

    logic                          advance;
    lcs_pkg::lcs_event_t           evt;
    lcs_pkg::lcs_result_t          result;
    lcs_pkg::level_table_t         levels;

    // Advance the event into the engine whenever the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign evt.valid     = advance;
    assign evt.kind      = in_kind_reg;
    assign evt.pin_level = in_pin_reg;

    lcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (levels)
    );

    lcs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .evt     (evt),
        .levels  (levels),
        .result  (result)
    );

    // Input register: capture on transfer, drop once passed on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_pin_reg  <= s_pin_level;
        end
    end

    // Result register: load with the post-event state, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_leds          = out_reg.leds;
    assign m_pattern_index = out_reg.pattern_index;
    assign m_speed_index   = out_reg.speed_index;

endmodule
`default_nettype wire

@@ rtl/core/lcs_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LED chaser duration registers
// Five step-duration registers written through the configuration channel.
// ----------------------------------------------------------------------------
module lcs_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcs_pkg::MS_W-1:0]       cfg_data,
    output lcs_pkg::level_table_t               levels
);

    lcs_pkg::level_table_t levels_reg;

    assign cfg_ready = 1'b1;
    assign levels    = levels_reg;

    // Drop writes to indexes beyond the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg[0] <= lcs_pkg::LEVEL0_RESET;
            levels_reg[1] <= lcs_pkg::LEVEL1_RESET;
            levels_reg[2] <= lcs_pkg::LEVEL2_RESET;
            levels_reg[3] <= lcs_pkg::LEVEL3_RESET;
            levels_reg[4] <= lcs_pkg::LEVEL4_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lcs_pkg::REG_LEVEL0: levels_reg[0] <= cfg_data;
                lcs_pkg::REG_LEVEL1: levels_reg[1] <= cfg_data;
                lcs_pkg::REG_LEVEL2: levels_reg[2] <= cfg_data;
                lcs_pkg::REG_LEVEL3: levels_reg[3] <= cfg_data;
                lcs_pkg::REG_LEVEL4: levels_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/lcs_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LED chaser sequencing engine
// Holds the chaser state and applies one event per cycle.
// ----------------------------------------------------------------------------
module lcs_engine (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lcs_pkg::lcs_event_t   evt,
    input  wire lcs_pkg::level_table_t levels,
    output lcs_pkg::lcs_result_t       result
);

    logic [lcs_pkg::PAT_W-1:0]   pattern_sel_reg,     pattern_sel_next;
    logic [lcs_pkg::SPEED_W-1:0] speed_sel_reg,       speed_sel_next;
    logic                        last_pin_reg,        last_pin_next;
    logic                        restart_pending_reg, restart_pending_next;
    logic [lcs_pkg::POS_W-1:0]   step_pos_reg,        step_pos_next;
    logic [lcs_pkg::MS_W-1:0]    elapsed_ms_reg,      elapsed_ms_next;
    logic [lcs_pkg::MS_W-1:0]    step_duration_reg,   step_duration_next;
    logic [lcs_pkg::LED_W-1:0]   led_drive_reg,       led_drive_next;

    logic [lcs_pkg::MS_W-1:0]    dur_eff;
    logic [lcs_pkg::MS_W-1:0]    elapsed_inc;
    logic [lcs_pkg::POS_W:0]     pos_inc;
    logic [lcs_pkg::POS_W:0]     steps;
    logic [lcs_pkg::POS_W-1:0]   new_pos;
    logic [lcs_pkg::MS_W-1:0]    level_sel;

    always_comb begin
        case (speed_sel_reg)
            3'd1:    level_sel = levels[1];
            3'd2:    level_sel = levels[2];
            3'd3:    level_sel = levels[3];
            3'd4:    level_sel = levels[4];
            default: level_sel = levels[0];
        endcase
    end

    assign dur_eff     = (step_duration_reg == '0) ? 12'd1 : step_duration_reg;
    assign elapsed_inc = elapsed_ms_reg + 12'd1;
    assign pos_inc     = {1'b0, step_pos_reg} + 3'd1;
    assign steps       = (pattern_sel_reg == lcs_pkg::PAT_ALT) ? 3'd2 : 3'd4;
    assign new_pos     = (restart_pending_reg || pos_inc >= steps) ? '0
                                                                   : pos_inc[1:0];

    always_comb begin
        pattern_sel_next     = pattern_sel_reg;
        speed_sel_next       = speed_sel_reg;
        last_pin_next        = last_pin_reg;
        restart_pending_next = restart_pending_reg;
        step_pos_next        = step_pos_reg;
        elapsed_ms_next      = elapsed_ms_reg;
        step_duration_next   = step_duration_reg;
        led_drive_next       = led_drive_reg;
        if (evt.valid) begin
            case (evt.kind)
                lcs_pkg::KIND_TICK: begin
                    if (elapsed_inc < dur_eff && elapsed_inc != '0) begin
                        elapsed_ms_next = elapsed_inc;
                    end else begin
                        // Start the next step, latching its duration
                        restart_pending_next = 1'b0;
                        step_pos_next        = new_pos;
                        elapsed_ms_next      = '0;
                        step_duration_next   = level_sel;
                        led_drive_next       = lcs_pkg::leds_for(pattern_sel_reg, new_pos);
                    end
                end
                lcs_pkg::KIND_PRESS: begin
                    pattern_sel_next = (pattern_sel_reg == lcs_pkg::PAT_ALT)
                                       ? lcs_pkg::PAT_LEFT : pattern_sel_reg + 2'd1;
                    restart_pending_next = 1'b1;
                end
                lcs_pkg::KIND_SPEED: begin
                    if (!evt.pin_level && last_pin_reg) begin
                        speed_sel_next = (speed_sel_reg == lcs_pkg::SPEED_MAX)
                                         ? lcs_pkg::SPEED_MIN : speed_sel_reg + 3'd1;
                        restart_pending_next = 1'b1;
                    end else if (evt.pin_level && !last_pin_reg) begin
                        speed_sel_next = (speed_sel_reg == lcs_pkg::SPEED_MIN)
                                         ? lcs_pkg::SPEED_MAX : speed_sel_reg - 3'd1;
                        restart_pending_next = 1'b1;
                    end
                    last_pin_next = evt.pin_level;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_sel_reg     <= lcs_pkg::PAT_LEFT;
            speed_sel_reg       <= lcs_pkg::SPEED_RESET;
            last_pin_reg        <= 1'b1;
            restart_pending_reg <= 1'b0;
            step_pos_reg        <= '0;
            elapsed_ms_reg      <= '0;
            step_duration_reg   <= lcs_pkg::LEVEL2_RESET;
            led_drive_reg       <= lcs_pkg::LED_FIRST;
        end else begin
            pattern_sel_reg     <= pattern_sel_next;
            speed_sel_reg       <= speed_sel_next;
            last_pin_reg        <= last_pin_next;
            restart_pending_reg <= restart_pending_next;
            step_pos_reg        <= step_pos_next;
            elapsed_ms_reg      <= elapsed_ms_next;
            step_duration_reg   <= step_duration_next;
            led_drive_reg       <= led_drive_next;
        end
    end

    assign result.leds          = led_drive_next;
    assign result.pattern_index = pattern_sel_next;
    assign result.speed_index   = speed_sel_next;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// LED chaser sequencer core testbench
// Drives millisecond ticks, pattern presses and speed-pin samples into the
// core, predicts every result from a behavioural copy of the sequencer and
// compares each field. Durations are reprogrammed between phases while the
// core is idle, and both channels are throttled at random.
// ----------------------------------------------------------------------------
module tb_top;

    // Kind code with no meaning to the core; it must leave the state alone
    localparam logic [lcs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Duration register indexes beyond the table; writes here are dropped
    localparam logic [lcs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
    localparam logic [lcs_pkg::CFG_IDX_W-1:0] REG_SPARE_MID = 3'd6;
    localparam logic [lcs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    localparam int unsigned DRAIN_LIMIT     = 5000;
    localparam int unsigned PHASE_EVENTS    = 115;
    localparam int unsigned PHASE_NUM       = 6;

    // ------------------------------------------------------------------------
    // Sequencer prediction and result store
    // ------------------------------------------------------------------------
    class chaser_scoreboard;
        lcs_pkg::step_ms_t            levels[lcs_pkg::LEVEL_NUM];
        logic [lcs_pkg::PAT_W-1:0]    pat_sel;
        logic [lcs_pkg::SPEED_W-1:0]  speed_lvl;
        logic                         prev_pin;
        logic                         restart_armed;
        logic [lcs_pkg::POS_W-1:0]    step_pos;
        lcs_pkg::step_ms_t            elapsed_ms;
        lcs_pkg::step_ms_t            step_len;
        logic [lcs_pkg::LED_W-1:0]    led_drive;
        lcs_pkg::lcs_result_t         expected_q[$];
        int unsigned                  failures;
        int unsigned                  checked;
        int unsigned                  kind_seen[4];

        function new();
            levels        = '{lcs_pkg::LEVEL0_RESET, lcs_pkg::LEVEL1_RESET,
                              lcs_pkg::LEVEL2_RESET, lcs_pkg::LEVEL3_RESET,
                              lcs_pkg::LEVEL4_RESET};
            pat_sel       = lcs_pkg::PAT_LEFT;
            speed_lvl     = lcs_pkg::SPEED_RESET;
            prev_pin      = 1'b1;
            restart_armed = 1'b0;
            step_pos      = '0;
            elapsed_ms    = '0;
            step_len      = lcs_pkg::LEVEL2_RESET;
            led_drive     = lcs_pkg::LED_FIRST;
            failures      = 0;
            checked       = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void set_level(input logic [lcs_pkg::CFG_IDX_W-1:0] idx,
                                input lcs_pkg::step_ms_t value);
            if (idx < lcs_pkg::LEVEL_NUM) levels[idx] = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Advance the predicted state by one event and queue the result
        function void note_event(input logic [lcs_pkg::KIND_W-1:0] kind, input logic pin);
            lcs_pkg::step_ms_t         dur;
            int unsigned               steps;
            logic [lcs_pkg::LED_W-1:0] lit;
            lcs_pkg::lcs_result_t      want;
            kind_seen[kind]++;
            case (kind)
                lcs_pkg::KIND_TICK: begin
                    dur        = (step_len != '0) ? step_len : lcs_pkg::step_ms_t'(1);
                    elapsed_ms = elapsed_ms + 1'b1;
                    if (elapsed_ms >= dur || elapsed_ms == '0) begin
                        steps = (pat_sel == lcs_pkg::PAT_ALT) ? 2 : 4;
                        if (restart_armed || int'(step_pos) + 1 >= steps)
                            step_pos = '0;
                        else
                            step_pos = step_pos + 1'b1;
                        restart_armed = 1'b0;
                        elapsed_ms    = '0;
                        step_len      = levels[(speed_lvl < lcs_pkg::LEVEL_NUM) ?
                                               speed_lvl : lcs_pkg::SPEED_MIN];
                        if (pat_sel == lcs_pkg::PAT_ALT) begin
                            led_drive = step_pos[0] ? lcs_pkg::LED_ODD : lcs_pkg::LED_EVEN;
                        end else begin
                            lit       = lcs_pkg::LED_FIRST << step_pos;
                            led_drive = (pat_sel == lcs_pkg::PAT_RIGHT) ?
                                        {lit[0], lit[1], lit[2], lit[3]} : lit;
                        end
                    end
                end
                lcs_pkg::KIND_PRESS: begin
                    pat_sel       = (pat_sel == lcs_pkg::PAT_ALT) ? lcs_pkg::PAT_LEFT
                                                                  : pat_sel + 1'b1;
                    restart_armed = 1'b1;
                end
                lcs_pkg::KIND_SPEED: begin
                    if (!pin && prev_pin) begin
                        speed_lvl     = (speed_lvl == lcs_pkg::SPEED_MAX) ?
                                        lcs_pkg::SPEED_MIN : speed_lvl + 1'b1;
                        restart_armed = 1'b1;
                    end else if (pin && !prev_pin) begin
                        speed_lvl     = (speed_lvl == lcs_pkg::SPEED_MIN) ?
                                        lcs_pkg::SPEED_MAX : speed_lvl - 1'b1;
                        restart_armed = 1'b1;
                    end
                    prev_pin = pin;
                end
                default: ;
            endcase
            want.leds          = led_drive;
            want.pattern_index = pat_sel;
            want.speed_index   = speed_lvl;
            expected_q.push_back(want);
        endfunction

        function void check_result(input lcs_pkg::lcs_result_t got);
            lcs_pkg::lcs_result_t want;
            if (expected_q.size() == 0) begin
                $error("result with no event outstanding: leds %0h pattern %0d speed %0d",
                       got.leds, got.pattern_index, got.speed_index);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.leds !== want.leds) begin
                $error("leds: expected %0h, got %0h", want.leds, got.leds);
                failures++;
            end
            if (got.pattern_index !== want.pattern_index) begin
                $error("pattern_index: expected %0d, got %0d",
                       want.pattern_index, got.pattern_index);
                failures++;
            end
            if (got.speed_index !== want.speed_index) begin
                $error("speed_index: expected %0d, got %0d",
                       want.speed_index, got.speed_index);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; every input of the core starts at a known value
    // ------------------------------------------------------------------------
    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [lcs_pkg::KIND_W-1:0]    s_kind          = lcs_pkg::KIND_TICK;
    logic                          s_pin_level     = 1'b1;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic [lcs_pkg::LED_W-1:0]     m_leds;
    logic [lcs_pkg::PAT_W-1:0]     m_pattern_index;
    logic [lcs_pkg::SPEED_W-1:0]   m_speed_index;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index       = lcs_pkg::REG_LEVEL0;
    logic [lcs_pkg::MS_W-1:0]      cfg_data        = '0;

    logic                          hold_off_req    = 1'b0;
    int unsigned                   tx_idle_pct     = 18;
    int unsigned                   rx_idle_pct     = 68;
    int unsigned                   cfg_writes      = 0;
    int unsigned                   drain_cycles;

    chaser_scoreboard sb = new();

    led_chaser_sequencer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_pin_level     (s_pin_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_leds          (m_leds),
        .m_pattern_index (m_pattern_index),
        .m_speed_index   (m_speed_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Safety net: a hung handshake ends the run here
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering transfers
    // meanwhile and the core fills up and drops s_ready.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Check every result transfer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(lcs_pkg::lcs_result_t'{m_leds, m_pattern_index, m_speed_index});
    end

    // ------------------------------------------------------------------------
    // Event side
    // ------------------------------------------------------------------------

    // Drop valid for a random gap, or not at all
    task automatic sender_gap();
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(3, 1);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Offer one event, hold it until the transfer, then note it
    task automatic send_event(input logic [lcs_pkg::KIND_W-1:0] kind, input logic pin);
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_pin_level <= pin;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(kind, pin);
        sender_gap();
    endtask

    // Stop offering and wait until every predicted result has been taken,
    // then allow the core's pipeline to settle
    task automatic quiesce();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the whole duration table plus one index past its end
    task automatic program_levels(input lcs_pkg::step_ms_t l0, input lcs_pkg::step_ms_t l1,
                                  input lcs_pkg::step_ms_t l2, input lcs_pkg::step_ms_t l3,
                                  input lcs_pkg::step_ms_t l4,
                                  input logic [lcs_pkg::CFG_IDX_W-1:0] spare_idx,
                                  input lcs_pkg::step_ms_t spare_data);
        logic [lcs_pkg::CFG_IDX_W-1:0] idx_list[6];
        lcs_pkg::step_ms_t             data_list[6];
        idx_list  = '{lcs_pkg::REG_LEVEL0, lcs_pkg::REG_LEVEL1, lcs_pkg::REG_LEVEL2,
                      lcs_pkg::REG_LEVEL3, lcs_pkg::REG_LEVEL4, spare_idx};
        data_list = '{l0, l1, l2, l3, l4, spare_data};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= data_list[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_level(idx_list[i], data_list[i]);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // Random event mix: mostly ticks, with presses, speed samples and the
    // odd unused kind. Optionally request the long hold-off, or pause until
    // the core has drained, part-way through.
    task automatic run_phase(input int n, input int hold_at, input int pause_at);
        int unsigned                pick;
        logic [lcs_pkg::KIND_W-1:0] kind;
        logic                       pin;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_off_req <= 1'b1;
            if (i == pause_at) quiesce();
            pick = $urandom_range(99);
            pin  = 1'($urandom_range(1, 0));
            if (pick < 62)      kind = lcs_pkg::KIND_TICK;
            else if (pick < 72) kind = lcs_pkg::KIND_PRESS;
            else if (pick < 95) kind = lcs_pkg::KIND_SPEED;
            else                kind = KIND_UNUSED;
            send_event(kind, pin);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes straight after reset: widest step, shortest, a zero
        // (treated as one millisecond) and a dropped write past the table
        program_levels(12'hFFF, 12'd1, 12'd0, 12'd3, 12'hFFF, REG_SPARE_LO, 12'hABC);

        // Directed: unused kind with both pin levels, speed pin held high,
        // a falling edge, held low, a rising edge, then presses round the
        // pattern wrap. The LEDs keep the running step while the pattern
        // index moves on.
        send_event(lcs_pkg::KIND_TICK, 1'b0);
        send_event(KIND_UNUSED, 1'b0);
        send_event(KIND_UNUSED, 1'b1);
        send_event(lcs_pkg::KIND_SPEED, 1'b1);
        send_event(lcs_pkg::KIND_SPEED, 1'b0);
        send_event(lcs_pkg::KIND_SPEED, 1'b0);
        send_event(lcs_pkg::KIND_SPEED, 1'b1);
        repeat (4) send_event(lcs_pkg::KIND_PRESS, 1'b0);

        // The first step still runs on the duration latched at reset, so tick
        // it out; the restart then picks up the zero-length table entry
        repeat (lcs_pkg::LEVEL2_RESET - 1)
            send_event(lcs_pkg::KIND_TICK, 1'($urandom_range(1, 0)));

        // Alternating pattern, stepping every tick
        send_event(lcs_pkg::KIND_PRESS, 1'b1);
        repeat (4) send_event(lcs_pkg::KIND_TICK, 1'b1);

        for (int ph = 0; ph < PHASE_NUM; ph++) begin
            quiesce();
            if (ph == 2) begin
                tx_idle_pct = 68;
                rx_idle_pct = 18;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                2: program_levels(12'd1, 12'd1, 12'd1, 12'd0, 12'd1, REG_SPARE_HI, 12'd0);
                5: program_levels(12'hFFF, 12'hFFF,
                                  lcs_pkg::step_ms_t'($urandom_range(3, 1)), 12'hFFF,
                                  12'hFFF, REG_SPARE_MID, 12'hFFF);
                default: program_levels(lcs_pkg::step_ms_t'($urandom_range(4095, 1)),
                                        lcs_pkg::step_ms_t'($urandom_range(4095, 1)),
                                        lcs_pkg::step_ms_t'($urandom_range(5, 0)),
                                        lcs_pkg::step_ms_t'($urandom_range(5, 0)),
                                        lcs_pkg::step_ms_t'($urandom_range(4095, 1)),
                                        REG_SPARE_MID,
                                        lcs_pkg::step_ms_t'($urandom_range(4095, 0)));
            endcase
            run_phase(PHASE_EVENTS, (ph == 1) ? 40 : -1, (ph == 3) ? 60 : -1);
        end

        // Drain, bounded, then let the pipeline settle
        s_valid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d predicted results never arrived", sb.pending());
            sb.failures++;
        end

        $display("Covered %0d ticks, %0d presses, %0d speed samples, %0d unused-kind events",
                 sb.kind_seen[lcs_pkg::KIND_TICK], sb.kind_seen[lcs_pkg::KIND_PRESS],
                 sb.kind_seen[lcs_pkg::KIND_SPEED], sb.kind_seen[KIND_UNUSED]);
        $display("Checked %0d results over %0d register writes, %s", sb.checked, cfg_writes,
                 "both throttle mixes, a free-running stretch and an output hold-off");
        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lcs_pkg.sv
rtl/core/lcs_cfg_regs.sv
rtl/core/lcs_engine.sv
rtl/core/led_chaser_sequencer_core.sv
bench/tb_top.sv
